@@ rtl/hse_pkg.sv @@
// Package with shared types, constants and SHA-1 helper functions for the HMAC engine.
`timescale 1ns / 1ps
package hse_pkg;

   localparam int LengthBitsDefault = 64;

   typedef enum logic [1:0] {
      OP_KEY    = 2'd0,
      OP_MSG    = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   // Source of the byte that the datapath appends to the running hash.
   typedef enum logic [2:0] {
      SRC_INPUT,
      SRC_KEY_IPAD,
      SRC_KEY_OPAD,
      SRC_KEY_RAW,
      SRC_PAD_80,
      SRC_ZERO,
      SRC_LENGTH,
      SRC_INNER
   } byte_src_type;

   // Command from the controller to the datapath, valid for one cycle.
   typedef struct packed {
      logic         hash_start;   // load IV, clear byte count
      logic         feed;         // append one byte
      byte_src_type src;
      logic [5:0]   index;        // key store / digest / length byte index
      logic         key_write;    // store input byte in key store
      logic         key_clear;    // clear one key store byte per command
      logic         key_load;     // copy digest byte into key store
      logic         inner_save;   // latch chain value as inner result
      logic [7:0]   data;         // input byte for feeding or key storage
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic        busy;          // block compression in progress
      logic [5:0]  fill;          // byte_count mod 64
   } status_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hc3d2e1f0;
   localparam logic [7:0]  IPAD = 8'h36;
   localparam logic [7:0]  OPAD = 8'h5c;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // Round constant by round number.
   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20)      k = 32'h5a827999;
      else if (r < 7'd40) k = 32'h6ed9eba1;
      else if (r < 7'd60) k = 32'h8f1bbcdc;
      else                k = 32'hca62c1d6;
      return k;
   endfunction

   // Round function by round number.
   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20)      f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else                f = b ^ c ^ d;
      return f;
   endfunction

endpackage

@@ rtl/hse_if.sv @@
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
interface hse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;
   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface hse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

@@ rtl/hse_datapath.sv @@
// SHA-1 datapath: byte assembly, message schedule, one round per cycle, key store.
`timescale 1ns / 1ps
module hse_datapath
   import hse_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   output logic [159:0] digest
);

   logic [31:0]  key_ff [16];
   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [31:0]  h_ff [5];
   logic [31:0]  h_in [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [159:0] inner_ff;
   logic [63:0]  count_ff, count_in;
   logic [63:0]  len_ff;
   logic [6:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic [7:0]   byte_val;
   logic [63:0]  bit_len;
   logic [31:0]  w_new, w_cur, t_val;
   logic [159:0] chain;
   logic [4:0]   key_sel;
   logic [7:0]   key_byte;

   assign chain  = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
   assign digest = chain;
   assign status = '{busy: busy_ff, fill: count_ff[5:0]};

   // The key store holds four key bytes per entry, first byte in the top lane.
   assign key_sel  = {~cmd.index[1:0], 3'b000};
   assign key_byte = key_ff[cmd.index[5:2]][key_sel +: 8];

   // Bit length, reduced to the configured width.
   always_comb begin
      bit_len = {count_ff[60:0], 3'b000};
      if (LENGTH_BITS < 64) begin
         bit_len = bit_len & ((64'd1 << LENGTH_BITS) - 64'd1);
      end
   end

   // Select the byte to append.
   always_comb begin
      case (cmd.src)
         SRC_INPUT:    byte_val = cmd.data;
         SRC_KEY_IPAD: byte_val = key_byte ^ IPAD;
         SRC_KEY_OPAD: byte_val = key_byte ^ OPAD;
         SRC_KEY_RAW:  byte_val = key_byte;
         SRC_PAD_80:   byte_val = PAD_BYTE;
         SRC_ZERO:     byte_val = 8'h00;
         SRC_LENGTH:   byte_val = len_ff[8'(7 - cmd.index[2:0]) * 8 +: 8];
         SRC_INNER:    byte_val = inner_ff[8'(19 - cmd.index[4:0]) * 8 +: 8];
         default:      byte_val = 8'h00;
      endcase
   end

   // The window holds the next sixteen schedule words; word 0 is consumed each round.
   assign w_cur = w_ff[0];
   assign w_new = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1
                | {31'd0, (w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31])};
   assign t_val = {a_ff[26:0], a_ff[31:27]} + round_f(round_ff, b_ff, c_ff, d_ff)
                + e_ff + round_k(round_ff) + w_cur;

   // Next-state logic of the hash core.
   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      count_in = count_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      if (busy_ff) begin
         a_in = t_val; b_in = a_ff; c_in = {b_ff[1:0], b_ff[31:2]}; d_in = c_ff; e_in = d_ff;
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = w_new;
         round_in = round_ff + 7'd1;
         if (round_ff == 7'd79) begin
            busy_in = 1'b0;
            h_in[0] = h_ff[0] + t_val;
            h_in[1] = h_ff[1] + a_ff;
            h_in[2] = h_ff[2] + {b_ff[1:0], b_ff[31:2]};
            h_in[3] = h_ff[3] + c_ff;
            h_in[4] = h_ff[4] + d_ff;
         end
      end else if (cmd.hash_start) begin
         h_in[0] = IV0; h_in[1] = IV1; h_in[2] = IV2; h_in[3] = IV3; h_in[4] = IV4;
         count_in = '0;
      end else if (cmd.feed) begin
         w_in[count_ff[5:2]] = w_ff[count_ff[5:2]];
         w_in[count_ff[5:2]][8'(3 - count_ff[1:0]) * 8 +: 8] = byte_val;
         count_in = count_ff + 64'd1;
         if (count_ff[5:0] == 6'd63) begin
            busy_in  = 1'b1;
            round_in = '0;
            a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3]; e_in = h_ff[4];
         end
      end
   end

   // Hash core registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         h_ff[0] <= IV0; h_ff[1] <= IV1; h_ff[2] <= IV2; h_ff[3] <= IV3; h_ff[4] <= IV4;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         h_ff     <= h_in;
      end
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      round_ff <= round_in;
   end

   // The message length is taken when padding starts, before the padding bytes count.
   always_ff @(posedge clock) begin
      if (!busy_ff && !cmd.hash_start && cmd.feed && cmd.src == SRC_PAD_80) begin
         len_ff <= bit_len;
      end
   end

   // Key store and saved inner digest.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) key_ff[i] <= 32'h0;
      end else if (cmd.key_write) begin
         key_ff[cmd.index[5:2]][key_sel +: 8] <= cmd.data;
      end else if (cmd.key_clear) begin
         key_ff[cmd.index[5:2]][key_sel +: 8] <= 8'h00;
      end else if (cmd.key_load) begin
         key_ff[cmd.index[5:2]][key_sel +: 8] <= chain[8'(19 - cmd.index[4:0]) * 8 +: 8];
      end
      if (cmd.inner_save) begin
         inner_ff <= chain;
      end
   end

endmodule

@@ rtl/hse_controller.sv @@
// Controller state machine that sequences key handling, padding and the outer hash.
`timescale 1ns / 1ps
module hse_controller
   import hse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   hse_req_if.sink       req,
   hse_rsp_if.source     rsp,
   input  status_type    status,
   input  logic [159:0]  digest,
   output cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WAIT,
      S_CLOSE_PAD,
      S_CLOSE_LOAD,
      S_IPAD,
      S_MSG_BYTE,
      S_FIN_PAD,
      S_OPAD,
      S_INNER,
      S_OUT_PAD,
      S_EMIT,
      S_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      PAD_START,
      PAD_ZERO,
      PAD_LEN
   } pad_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   pad_type     pad_ff, pad_in;
   logic [6:0]  idx_ff, idx_in;
   logic [6:0]  kcount_ff, kcount_in;
   logic        long_ff, long_in;
   logic        phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  word_ff, word_in;
   logic        vld_ff, vld_in;
   logic [31:0] dw_ff, dw_in;
   logic        idle;

   assign idle      = (state_ff == S_IDLE) && !status.busy;
   assign req.ready = idle;
   assign rsp.valid = vld_ff;
   assign rsp.digest_word = dw_ff;
   assign rsp.word_index  = word_ff;
   assign rsp.last_word   = (word_ff == 3'd4);

   // Last length byte of the padding shared by the key, inner and outer hashes; checked while the core is free.
   function automatic logic pad_step(input pad_type p, input logic [5:0] fill);
      return (p == PAD_LEN) && (fill == 6'd63);
   endfunction

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      pad_in    = pad_ff;
      idx_in    = idx_ff;
      kcount_in = kcount_ff;
      long_in   = long_ff;
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      byte_in   = byte_ff;
      word_in   = word_ff;
      vld_in    = vld_ff;
      dw_in     = dw_ff;
      cmd       = '0;
      cmd.src   = SRC_INPUT;
      cmd.data  = byte_ff;
      if (vld_ff && rsp.ready) begin
         vld_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (idle && req.valid) begin
               byte_in  = req.data_byte;
               cmd.data = req.data_byte;
               case (opcode_type'(req.opcode))
                  OP_KEY: begin
                     if (!phase_ff) begin
                        if (long_ff) begin
                           cmd.feed = 1'b1;
                        end else if (kcount_ff < 7'd64) begin
                           cmd.key_write = 1'b1;
                           cmd.index     = kcount_ff[5:0];
                           kcount_in     = kcount_ff + 7'd1;
                        end else begin
                           // Sixty-fifth byte: hash the stored key, then this byte.
                           long_in = 1'b1;
                           cmd.hash_start = 1'b1;
                           idx_in   = '0;
                           state_in = S_WAIT;
                           ret_in   = S_MSG_BYTE;
                           fin_in   = 1'b0;
                        end
                     end
                  end
                  OP_MSG, OP_FINISH: begin
                     fin_in = (req.opcode == OP_FINISH);
                     if (!phase_ff) begin
                        idx_in = '0;
                        pad_in = PAD_START;
                        if (long_ff) begin
                           state_in = S_CLOSE_PAD;
                        end else begin
                           cmd.hash_start = 1'b1;
                           state_in = S_IPAD;
                        end
                     end else if (req.opcode == OP_MSG) begin
                        cmd.feed = 1'b1;
                     end else begin
                        pad_in   = PAD_START;
                        state_in = S_FIN_PAD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Raw stored key as first block of the long-key hash.
         S_WAIT: begin
            cmd.feed  = 1'b1;
            cmd.src   = SRC_KEY_RAW;
            cmd.index = idx_ff[5:0];
            idx_in    = idx_ff + 7'd1;
            if (idx_ff == 7'd63) state_in = ret_ff;
         end
         // Feed the pending input byte (used after the stored key block).
         S_MSG_BYTE: begin
            if (!status.busy) begin
               cmd.feed = 1'b1;
               cmd.src  = SRC_INPUT;
               state_in = S_IDLE;
            end
         end
         // Pad the long-key, inner or outer hash.
         S_CLOSE_PAD, S_FIN_PAD, S_OUT_PAD: begin
            if (!status.busy) begin
               cmd.feed = 1'b1;
               case (pad_ff)
                  PAD_START: begin
                     cmd.src = SRC_PAD_80;
                     pad_in  = (status.fill == 6'd55) ? PAD_LEN : PAD_ZERO;
                     idx_in  = '0;
                  end
                  PAD_ZERO: begin
                     cmd.src = SRC_ZERO;
                     if (status.fill == 6'd55) pad_in = PAD_LEN;
                  end
                  default: begin
                     cmd.src   = SRC_LENGTH;
                     cmd.index = idx_ff[5:0];
                     idx_in    = idx_ff + 7'd1;
                  end
               endcase
               if (pad_step(pad_ff, status.fill)) begin
                  idx_in = '0;
                  case (state_ff)
                     S_CLOSE_PAD: state_in = S_CLOSE_LOAD;
                     S_FIN_PAD:   state_in = S_OPAD;
                     default: begin
                        state_in = S_EMIT;
                        word_in  = '0;
                     end
                  endcase
               end
            end
         end
         // Write the key digest into the first 20 key store bytes and clear the rest.
         S_CLOSE_LOAD: begin
            if (!status.busy) begin
               cmd.index = idx_ff[5:0];
               if (idx_ff < 7'd20) cmd.key_load = 1'b1;
               else                cmd.key_clear = 1'b1;
               idx_in = idx_ff + 7'd1;
               if (idx_ff == 7'd63) begin
                  idx_in = '0;
                  cmd.hash_start = 1'b0;
                  state_in = S_IPAD;
               end
            end
         end
         // Key XOR inner pad as the first inner block.
         S_IPAD: begin
            if (!status.busy) begin
               if (idx_ff == 7'd0 && long_ff && status.fill != 6'd0) begin
                  cmd.hash_start = 1'b1;
               end else if (idx_ff == 7'd0 && long_ff) begin
                  cmd.hash_start = 1'b1;
                  long_in = 1'b0;
               end else begin
                  cmd.feed  = 1'b1;
                  cmd.src   = SRC_KEY_IPAD;
                  cmd.index = idx_ff[5:0];
                  idx_in    = idx_ff + 7'd1;
                  if (idx_ff == 7'd63) begin
                     phase_in = 1'b1;
                     idx_in   = '0;
                     pad_in   = PAD_START;
                     state_in = fin_ff ? S_FIN_PAD : S_MSG_BYTE;
                  end
               end
            end
         end
         // Save inner digest, start outer hash over key XOR outer pad.
         S_OPAD: begin
            if (!status.busy) begin
               if (idx_ff == 7'd0 && !fin_ff) begin
                  cmd.feed = 1'b1;
                  cmd.src  = SRC_KEY_OPAD;
                  cmd.index = 6'd0;
                  idx_in = 7'd1;
               end else if (idx_ff == 7'd0) begin
                  cmd.inner_save = 1'b1;
                  cmd.hash_start = 1'b1;
                  fin_in = 1'b0;
               end else begin
                  cmd.feed  = 1'b1;
                  cmd.src   = SRC_KEY_OPAD;
                  cmd.index = idx_ff[5:0];
                  idx_in    = idx_ff + 7'd1;
                  if (idx_ff == 7'd63) begin
                     idx_in   = '0;
                     state_in = S_INNER;
                  end
               end
            end
         end
         // Inner digest bytes into the outer hash.
         S_INNER: begin
            if (!status.busy) begin
               cmd.feed  = 1'b1;
               cmd.src   = SRC_INNER;
               cmd.index = idx_ff[5:0];
               idx_in    = idx_ff + 7'd1;
               if (idx_ff == 7'd19) begin
                  idx_in   = '0;
                  pad_in   = PAD_START;
                  state_in = S_OUT_PAD;
               end
            end
         end
         // Present the five digest words.
         S_EMIT: begin
            if (!status.busy && (!vld_ff || rsp.ready)) begin
               vld_in = 1'b1;
               dw_in  = digest[8'(4 - (word_ff + (vld_ff ? 3'd1 : 3'd0))) * 32 +: 32];
               if (vld_ff) word_in = word_ff + 3'd1;
               if (vld_ff && word_ff == 3'd3) begin
                  state_in = S_CLEAR;
                  idx_in   = '0;
               end
            end
         end
         // Wait for the last word, then clear key and restart the hash.
         S_CLEAR: begin
            if (!vld_ff || rsp.ready) begin
               if (idx_ff == 7'd0) begin
                  vld_in = vld_ff && !rsp.ready;
               end
               cmd.key_clear = 1'b1;
               cmd.index     = idx_ff[5:0];
               idx_in        = idx_ff + 7'd1;
               if (idx_ff == 7'd63) begin
                  cmd.hash_start = 1'b1;
                  kcount_in = '0;
                  long_in   = 1'b0;
                  phase_in  = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         pad_ff    <= PAD_START;
         idx_ff    <= '0;
         kcount_ff <= '0;
         long_ff   <= 1'b0;
         phase_ff  <= 1'b0;
         fin_ff    <= 1'b0;
         word_ff   <= '0;
         vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         pad_ff    <= pad_in;
         idx_ff    <= idx_in;
         kcount_ff <= kcount_in;
         long_ff   <= long_in;
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         word_ff   <= word_in;
         vld_ff    <= vld_in;
      end
      byte_ff <= byte_in;
      dw_ff   <= dw_in;
   end

endmodule

@@ rtl/hmac_sha1_engine_unit.sv @@
// Top level of the streaming HMAC-SHA1 engine.
`timescale 1ns / 1ps
// Usage:
//   The request channel carries one byte word at a time with an opcode: key byte,
//   message byte or finish. Key bytes come first; the first message byte or a
//   finish closes the key phase. Key bytes after that are dropped.
//   A finish produces five response words on the response channel, the HMAC
//   digest in big-endian order, with word_index 0..4 and last_word on the fifth.
//   The byte that completes a 64-byte block starts the SHA-1 core, which runs
//   one round a cycle; no request is accepted while the core is busy.
//   Closing the key phase feeds the key XOR inner pad as one block and
//   compresses it; a key over 64 bytes must first be padded, hashed and
//   reloaded. A finish pads the inner hash, runs the outer hash, then gives
//   one word per cycle while the receiver is ready, followed by a sweep that
//   clears the key store.
//   Reset is synchronous and returns the block to the key phase with an empty key.
//   If the receiver stalls, the current word is held and the engine waits.
module hmac_sha1_engine_unit
   import hse_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input logic        clock,
   input logic        reset,
   hse_req_if.sink    req,
   hse_rsp_if.source  rsp
);

   cmd_type      cmd;
   status_type   status;
   logic [159:0] digest;

   hse_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .status (status),
      .digest (digest),
      .cmd    (cmd)
   );

   hse_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .digest  (digest)
   );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the streaming HMAC-SHA1 engine.
`timescale 1ns / 1ps
module tb_top;
   import hse_pkg::*;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hse_req_if req ();
   hse_rsp_if rsp ();

   hmac_sha1_engine_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #6 clock = ~clock;

   // Predictor state for the keyed hash.
   logic [31:0] hv [5];
   logic [7:0]  blk_buf [64];
   logic [63:0] nbytes;
   logic [7:0]  key_mem [64];
   int          key_len;
   bit          long_key;
   bit          in_msg;

   req_word_type   pending_words [$];
   digest_out_type digest_queue [$];
   int             errors = 0;
   int             hold_cycles = 0;
   bit             req_taken = 1'b0;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void sha_compress(input logic [7:0] b [64]);
      logic [31:0] w [80];
      logic [31:0] a, bb, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = hv[0]; bb = hv[1]; c = hv[2]; d = hv[3]; e = hv[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (bb & c) | (~bb & d); k = 32'h5a827999;
         end else if (i < 40) begin
            f = bb ^ c ^ d; k = 32'h6ed9eba1;
         end else if (i < 60) begin
            f = (bb & c) | (bb & d) | (c & d); k = 32'h8f1bbcdc;
         end else begin
            f = bb ^ c ^ d; k = 32'hca62c1d6;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(bb, 30); bb = a; a = t;
      end
      hv[0] += a; hv[1] += bb; hv[2] += c; hv[3] += d; hv[4] += e;
   endfunction

   function automatic void sha_init();
      hv[0] = IV0; hv[1] = IV1; hv[2] = IV2; hv[3] = IV3; hv[4] = IV4;
      nbytes = '0;
   endfunction

   function automatic void sha_feed(input logic [7:0] v);
      blk_buf[nbytes[5:0]] = v;
      nbytes++;
      if (nbytes[5:0] == 6'd0) sha_compress(blk_buf);
   endfunction

   function automatic void sha_start_keyed(input logic [7:0] pad);
      logic [7:0] b [64];
      sha_init();
      for (int i = 0; i < 64; i++) b[i] = key_mem[i] ^ pad;
      sha_compress(b);
      nbytes = 64;
   endfunction

   function automatic void sha_final(output logic [31:0] dg [5]);
      logic [63:0] bits;
      bits = nbytes << 3;
      sha_feed(PAD_BYTE);
      while (nbytes[5:0] != 6'd56) sha_feed(8'h00);
      for (int i = 0; i < 8; i++) sha_feed(bits[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) dg[i] = hv[i];
   endfunction

   function automatic void close_key();
      logic [31:0] kd [5];
      if (long_key) begin
         sha_final(kd);
         for (int i = 0; i < 64; i++) key_mem[i] = 8'h00;
         for (int i = 0; i < 20; i++) key_mem[i] = kd[i/4][31 - 8*(i%4) -: 8];
      end
      sha_start_keyed(IPAD);
      in_msg = 1'b1;
   endfunction

   function automatic void clear_key();
      for (int i = 0; i < 64; i++) key_mem[i] = 8'h00;
      key_len = 0; long_key = 1'b0; in_msg = 1'b0;
      sha_init();
   endfunction

   // Works out the digest words that one accepted request word causes.
   function automatic void predict_hmac(input req_word_type rw);
      logic [31:0] inner [5];
      logic [31:0] outer [5];
      digest_out_type o;
      case (rw.opcode)
         OP_KEY: begin
            if (!in_msg) begin
               if (long_key) sha_feed(rw.data_byte);
               else if (key_len < 64) begin
                  key_mem[key_len] = rw.data_byte;
                  key_len++;
               end else begin
                  long_key = 1'b1;
                  sha_init();
                  sha_compress(key_mem);
                  nbytes = 64;
                  sha_feed(rw.data_byte);
               end
            end
         end
         OP_MSG: begin
            if (!in_msg) close_key();
            sha_feed(rw.data_byte);
         end
         OP_FINISH: begin
            if (!in_msg) close_key();
            sha_final(inner);
            sha_start_keyed(OPAD);
            for (int i = 0; i < 20; i++) sha_feed(inner[i/4][31 - 8*(i%4) -: 8]);
            sha_final(outer);
            for (int i = 0; i < 5; i++) begin
               o.digest_word = outer[i];
               o.word_index = 3'(i);
               o.last_word = (i == 4);
               digest_queue.push_back(o);
            end
            clear_key();
         end
         default: ;
      endcase
   endfunction

   // Acceptance: predict at the rising edge and draw the gap before the next word.
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         predict_hmac('{req.opcode, req.data_byte});
         void'(pending_words.pop_front());
         req_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
         req_taken = 1'b1;
      end
   end

   // Driver: offers queued words at the falling edge with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req.valid <= 1'b0;
            req_gap--;
         end else if (pending_words.size() > 0) begin
            req.opcode <= pending_words[0].opcode;
            req.data_byte <= pending_words[0].data_byte;
            req.valid <= 1'b1;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with random waits and a long hold-off counted here.
   int rsp_wait = 0;
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles--;
      end else if (rsp_wait > 0) begin
         rsp.ready <= 1'b0;
         rsp_wait--;
      end else rsp.ready <= 1'b1;
   end

   // Monitor: compares every accepted digest word with the oldest expectation.
   always @(posedge clock) begin
      digest_out_type exp_w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected word %h idx %0d last %0b", $time,
                     rsp.digest_word, rsp.word_index, rsp.last_word);
            errors++;
         end else begin
            exp_w = digest_queue.pop_front();
            if (exp_w.digest_word !== rsp.digest_word) begin
               $display("%0t: digest_word expected %h actual %h", $time,
                        exp_w.digest_word, rsp.digest_word);
               errors++;
            end
            if (exp_w.word_index !== rsp.word_index) begin
               $display("%0t: word_index expected %0d actual %0d", $time,
                        exp_w.word_index, rsp.word_index);
               errors++;
            end
            if (exp_w.last_word !== rsp.last_word) begin
               $display("%0t: last_word expected %0b actual %0b", $time,
                        exp_w.last_word, rsp.last_word);
               errors++;
            end
         end
         rsp_wait = $urandom_range(0, 2) == 0 ? $urandom_range(0, 17) : 0;
      end
   end

   task automatic push_word(input opcode_type op, input logic [7:0] b);
      pending_words.push_back('{op, b});
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req.valid || digest_queue.size() > 0)
         @(posedge clock);
   endtask

   // Random messages: mostly well formed key, message, finish sequences.
   task automatic push_random_hmac(input int klen, input int mlen);
      for (int i = 0; i < klen; i++) push_word(OP_KEY, 8'($urandom));
      for (int i = 0; i < mlen; i++) begin
         if ($urandom_range(0, 9) == 0) push_word(OP_KEY, 8'($urandom));
         else if ($urandom_range(0, 14) == 0) push_word(OP_NONE, 8'($urandom));
         else push_word(OP_MSG, 8'($urandom));
      end
      push_word(OP_FINISH, 8'($urandom));
   endtask

   initial begin
      int issued;
      req.valid = 1'b0; req.opcode = OP_NONE; req.data_byte = 8'h00;
      rsp.ready = 1'b0;
      clear_key();
      for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty key and message, extreme bytes, ignored opcodes.
      push_word(OP_FINISH, 8'hff);
      push_word(OP_NONE, 8'hff);
      push_word(OP_KEY, 8'h00);
      push_word(OP_KEY, 8'hff);
      push_word(OP_MSG, 8'hff);
      push_word(OP_KEY, 8'h55);
      push_word(OP_MSG, 8'h00);
      push_word(OP_FINISH, 8'h00);
      push_word(OP_MSG, 8'haa);
      push_word(OP_FINISH, 8'h00);
      // Sender pauses until every expected word has come.
      wait_drained();

      // Long key of 65 bytes while the receiver holds off.
      hold_cycles = 3000;
      push_random_hmac(65, 0);
      push_random_hmac(1, 2);
      wait (hold_cycles == 0);
      wait_drained();

      // Random part: short keys and messages.
      issued = 0;
      while (issued < 45) begin
         int kl, ml;
         kl = $urandom_range(0, 6);
         ml = $urandom_range(0, 8);
         push_random_hmac(kl, ml);
         issued += kl + ml + 1;
      end
      wait_drained();
      repeat (100) @(posedge clock);
      if (errors == 0 && digest_queue.size() == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #50ms;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
rtl/hse_pkg.sv
rtl/hse_if.sv
rtl/hse_datapath.sv
rtl/hse_controller.sv
rtl/hmac_sha1_engine_unit.sv
sim/tb_top.sv
